@@ rtl/core/bpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, constants and arithmetic helpers for the boot power decision
// block: millivolt scaling, decision codes and the open-circuit capacity table.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int CODE_W  = 10;
  localparam int MV_W    = 13;
  localparam int CAP_W   = 7;
  localparam int WORD_W  = 16;
  localparam int PLUG_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Millivolt scaling as one constant multiply and a shift:
  // code * 7325 / 1000 and code * 5860 / 1000, truncated. The rounded-up
  // reciprocals keep the error far below the 1/40 and 1/50 steps of the exact quotients.
  localparam int SCALE_SHIFT = 20;
  localparam int SCALE_M_W   = 23;
  localparam logic [SCALE_M_W-1:0] ADAPTER_SCALE = 23'd7680820;
  localparam logic [SCALE_M_W-1:0] BATTERY_SCALE = 23'd6144656;

  localparam logic [MV_W-1:0] PLUG_MV  = 13'd3000;
  localparam logic [MV_W-1:0] LOW_MV   = 13'd3300;
  localparam logic [MV_W-1:0] WEAK_MV  = 13'd3700;
  localparam logic [MV_W:0]   OCV_OFFSET = 14'd62;
  localparam logic [CAP_W-1:0] NO_STEP_CAP = 7'd15;

  localparam int OCV_STEPS = 11;
  localparam logic [MV_W:0] OCV_STEP [OCV_STEPS] = '{
    14'd3420, 14'd3477, 14'd3534, 14'd3591, 14'd3624, 14'd3637,
    14'd3649, 14'd3661, 14'd3667, 14'd3673, 14'd3677
  };

  localparam int SAVED_VALID_BIT = 15;
  localparam int SAVED_CAP_LSB   = 8;

  // Adaptor type codes
  localparam logic [1:0] ADAPTOR_UNKNOWN   = 2'd0;
  localparam logic [1:0] ADAPTOR_WALL_ONLY = 2'd1;
  localparam logic [1:0] ADAPTOR_USB_ONLY  = 2'd2;
  localparam logic [1:0] ADAPTOR_BOTH      = 2'd3;

  // Plug state codes
  localparam logic [PLUG_W-1:0] PLUG_NONE     = 2'b00;
  localparam logic [PLUG_W-1:0] PLUG_USB_ONLY = 2'b10;

  // Register indexes on the configuration port (byte address 4*i)
  localparam logic [1:0] REG_ADAPTOR_TYPE   = 2'd0;
  localparam logic [1:0] REG_CHARGER_MODE   = 2'd1;
  localparam logic [1:0] REG_USE_HW_GAUGE   = 2'd2;
  localparam logic [1:0] REG_BOOT_CAP_THRESH = 2'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    DEC_NORMAL    = 2'd0,
    DEC_CHARGE    = 2'd1,
    DEC_LOW_POWER = 2'd2,
    DEC_SHUTOFF   = 2'd3
  } bpd_decision_t;

  typedef struct packed {
    logic [1:0]       adaptor_type;
    logic             charger_mode_enabled;
    logic             use_hw_gauge;
    logic [CAP_W-1:0] min_boot_cap;
  } bpd_cfg_t;

  // One classified sample set, as it waits in the queue
  typedef struct packed {
    logic [MV_W-1:0]   wall_mv;
    logic [MV_W-1:0]   usb_mv;
    logic [MV_W-1:0]   battery_mv;
    logic [PLUG_W-1:0] plug_state;
    logic              bat_low;
    logic              bat_weak;
    logic              battery_present;
    logic              skip_charger_once;
    logic [WORD_W-1:0] saved_cap_word;
    logic [CAP_W-1:0]  gauge_capacity;
  } bpd_item_t;

  typedef struct packed {
    bpd_decision_t     decision;
    logic [PLUG_W-1:0] plug_state;
    logic [MV_W-1:0]   wall_mv;
    logic [MV_W-1:0]   usb_mv;
    logic [MV_W-1:0]   battery_mv;
    logic [CAP_W-1:0]  capacity;
    logic              backlight_low;
    logic              clear_skip_flag;
    logic              disable_usb_wake;
  } bpd_result_t;

  function automatic logic [MV_W-1:0] scale_mv(input logic [CODE_W-1:0] code,
                                                input logic [SCALE_M_W-1:0] m);
    logic [CODE_W+SCALE_M_W-1:0] prod;
    prod = {{SCALE_M_W{1'b0}}, code} * {{CODE_W{1'b0}}, m};
    return prod[SCALE_SHIFT +: MV_W];
  endfunction

  // First table step above the open-circuit estimate, capped by a valid
  // saved capacity.
  function automatic logic [CAP_W-1:0] table_capacity(input logic [MV_W-1:0] bat_mv,
                                                       input logic [WORD_W-1:0] saved);
    logic [MV_W:0]    ocv;
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] saved_cap;
    ocv = {1'b0, bat_mv} + OCV_OFFSET;
    cap = NO_STEP_CAP;
    for (int i = OCV_STEPS - 1; i >= 0; i--) begin
      if (ocv < OCV_STEP[i]) begin
        cap = CAP_W'(i);
      end
    end
    saved_cap = saved[SAVED_CAP_LSB +: CAP_W];
    if (saved[SAVED_VALID_BIT] && (cap > saved_cap)) begin
      cap = saved_cap;
    end
    return cap;
  endfunction

endpackage

@@ rtl/core/boot_power_decision.sv @@
// ----------------------------------------------------------------------------
// boot_power_decision
// Boot power decision: millivolt scaling, plug detection and the choice
// between normal boot, charge mode, low-power shutdown and immediate shutoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample set per beat: three
//   converter codes, battery-present, skip-charger-once, the saved capacity
//   word and the gauge capacity. Output channel (out_valid/out_ready) returns
//   exactly one result beat per input beat, in order.
//   A beat accepted on the input is written into the queue and then moves to
//   the output register once that register is free. Throughput is one beat
//   per cycle while the receiver takes results; the front side does the
//   constant multiplies and compares, the back side the capacity table and
//   decision, with a two-entry queue between them. When the receiver stalls,
//   the result holds in the output register and the queue absorbs up to two more beats before in_ready drops.
//   Reset (rst, synchronous) empties the queue and output register and loads
//   the configuration defaults: adaptor type unknown, charge mode enabled,
//   table capacity, threshold 7.
//   Write configuration over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module boot_power_decision (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpd_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpd_pkg::DATA_W-1:0]    pwdata,
  output logic [bpd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpd_pkg::CODE_W-1:0]    wall_code,
  input  logic [bpd_pkg::CODE_W-1:0]    usb_code,
  input  logic [bpd_pkg::CODE_W-1:0]    battery_code,
  input  logic                          battery_present,
  input  logic                          skip_charger_once,
  input  logic [bpd_pkg::WORD_W-1:0]    saved_cap_word,
  input  logic [bpd_pkg::CAP_W-1:0]     gauge_capacity,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    decision,
  output logic [bpd_pkg::PLUG_W-1:0]    plug_state,
  output logic [bpd_pkg::MV_W-1:0]      wall_mv,
  output logic [bpd_pkg::MV_W-1:0]      usb_mv,
  output logic [bpd_pkg::MV_W-1:0]      battery_mv,
  output logic [bpd_pkg::CAP_W-1:0]     capacity,
  output logic                          backlight_low,
  output logic                          clear_skip_flag,
  output logic                          disable_usb_wake
);
  import bpd_pkg::*;

  bpd_cfg_t    cfg;
  bpd_item_t   q_item;
  bpd_item_t   q_head;
  bpd_result_t result;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  logic        cfg_write;
  logic [1:0]  reg_index;

  // --------------------------------------------------------------------------
  // Configuration registers: written in the APB access phase, zero-wait.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adaptor_type         <= ADAPTOR_UNKNOWN;
      cfg.charger_mode_enabled <= 1'b1;
      cfg.use_hw_gauge         <= 1'b0;
      cfg.min_boot_cap         <= 7'd7;
    end else if (cfg_write) begin
      case (reg_index)
        REG_ADAPTOR_TYPE:    cfg.adaptor_type         <= pwdata[1:0];
        REG_CHARGER_MODE:    cfg.charger_mode_enabled <= pwdata[0];
        REG_USE_HW_GAUGE:    cfg.use_hw_gauge         <= pwdata[0];
        REG_BOOT_CAP_THRESH: cfg.min_boot_cap         <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    case (reg_index)
      REG_ADAPTOR_TYPE:    prdata = DATA_W'(cfg.adaptor_type);
      REG_CHARGER_MODE:    prdata = DATA_W'(cfg.charger_mode_enabled);
      REG_USE_HW_GAUGE:    prdata = DATA_W'(cfg.use_hw_gauge);
      REG_BOOT_CAP_THRESH: prdata = DATA_W'(cfg.min_boot_cap);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: scale and classify each beat into the queue.
  // --------------------------------------------------------------------------
  bpd_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .wall_code         (wall_code),
    .usb_code          (usb_code),
    .battery_code      (battery_code),
    .battery_present   (battery_present),
    .skip_charger_once (skip_charger_once),
    .saved_cap_word    (saved_cap_word),
    .gauge_capacity    (gauge_capacity),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_item)
  );

  // --------------------------------------------------------------------------
  // Queue: decouples acceptance from output stalls.
  // --------------------------------------------------------------------------
  bpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // --------------------------------------------------------------------------
  // Back: decide and register the result.
  // --------------------------------------------------------------------------
  bpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  assign decision         = result.decision;
  assign plug_state       = result.plug_state;
  assign wall_mv          = result.wall_mv;
  assign usb_mv           = result.usb_mv;
  assign battery_mv       = result.battery_mv;
  assign capacity         = result.capacity;
  assign backlight_low    = result.backlight_low;
  assign clear_skip_flag  = result.clear_skip_flag;
  assign disable_usb_wake = result.disable_usb_wake;

`ifndef SYNTH
  // Plug bits must agree with the reported voltages
  a_plug_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (plug_state[0] == (wall_mv > PLUG_MV)) &&
                  (plug_state[1] == (usb_mv > PLUG_MV)))
    else $error("plug_state disagrees with wall_mv/usb_mv");

  // Shutoff and charge paths never carry a capacity estimate
  a_cap_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (decision == DEC_SHUTOFF || decision == DEC_CHARGE) |-> capacity == '0)
    else $error("capacity set on a path that does not estimate it");

  // Backlight-low only with a USB-only charge
  a_backlight: assert property (@(posedge clk) disable iff (rst)
    out_valid && backlight_low |-> decision == DEC_CHARGE && plug_state == PLUG_USB_ONLY)
    else $error("backlight_low without a USB-only charge");

  // Input backpressure only when the queue is really full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_full && out_valid)
    else $error("in_ready low while the queue has room");
`endif

endmodule

@@ rtl/core/bpd_front.sv @@
// ----------------------------------------------------------------------------
// bpd_front
// Input side: scale the converter codes to millivolts, derive the plug state
// and battery level flags, and hand the classified item to the queue.
// ----------------------------------------------------------------------------
module bpd_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpd_pkg::CODE_W-1:0]   wall_code,
  input  logic [bpd_pkg::CODE_W-1:0]   usb_code,
  input  logic [bpd_pkg::CODE_W-1:0]   battery_code,
  input  logic                         battery_present,
  input  logic                         skip_charger_once,
  input  logic [bpd_pkg::WORD_W-1:0]   saved_cap_word,
  input  logic [bpd_pkg::CAP_W-1:0]    gauge_capacity,
  input  logic                         q_full,
  output logic                         q_push,
  output bpd_pkg::bpd_item_t           q_item
);
  import bpd_pkg::*;

  logic [MV_W-1:0] wall_mv;
  logic [MV_W-1:0] usb_mv;
  logic [MV_W-1:0] bat_mv;

  assign wall_mv = scale_mv(wall_code, ADAPTER_SCALE);
  assign usb_mv  = scale_mv(usb_code, ADAPTER_SCALE);
  assign bat_mv  = scale_mv(battery_code, BATTERY_SCALE);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.wall_mv           = wall_mv;
    q_item.usb_mv            = usb_mv;
    q_item.battery_mv        = bat_mv;
    q_item.plug_state        = {usb_mv > PLUG_MV, wall_mv > PLUG_MV};
    q_item.bat_low           = bat_mv < LOW_MV;
    q_item.bat_weak          = bat_mv < WEAK_MV;
    q_item.battery_present   = battery_present;
    q_item.skip_charger_once = skip_charger_once;
    q_item.saved_cap_word    = saved_cap_word;
    q_item.gauge_capacity    = gauge_capacity;
  end

endmodule

@@ rtl/core/bpd_queue.sv @@
// ----------------------------------------------------------------------------
// bpd_queue
// Short register queue between the front and back sides.
// ----------------------------------------------------------------------------
module bpd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bpd_pkg::bpd_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output bpd_pkg::bpd_item_t head
);
  import bpd_pkg::*;

  bpd_item_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = count == Q_CNT_W'(Q_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/bpd_back.sv @@
// ----------------------------------------------------------------------------
// bpd_back
// Output side: take the queue head, choose the boot decision and capacity,
// and hold the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module bpd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bpd_pkg::bpd_cfg_t     cfg,
  input  logic                  q_not_empty,
  input  bpd_pkg::bpd_item_t    q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpd_pkg::bpd_result_t  result
);
  import bpd_pkg::*;

  bpd_result_t      res_next;
  logic [CAP_W-1:0] est_cap;

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    est_cap = cfg.use_hw_gauge ? q_head.gauge_capacity
                               : table_capacity(q_head.battery_mv, q_head.saved_cap_word);

    res_next.decision         = DEC_NORMAL;
    res_next.plug_state       = q_head.plug_state;
    res_next.wall_mv          = q_head.wall_mv;
    res_next.usb_mv           = q_head.usb_mv;
    res_next.battery_mv       = q_head.battery_mv;
    res_next.capacity         = '0;
    res_next.backlight_low    = 1'b0;
    res_next.clear_skip_flag  = 1'b0;
    res_next.disable_usb_wake = cfg.adaptor_type == ADAPTOR_WALL_ONLY;

    if (q_head.plug_state != PLUG_NONE) begin
      if (q_head.skip_charger_once) begin
        res_next.clear_skip_flag = 1'b1;
      end else if (cfg.charger_mode_enabled && q_head.battery_present) begin
        if (q_head.plug_state == PLUG_USB_ONLY) begin
          if (cfg.adaptor_type != ADAPTOR_WALL_ONLY) begin
            res_next.decision      = DEC_CHARGE;
            res_next.backlight_low = q_head.bat_low;
          end
        end else begin
          res_next.decision = DEC_CHARGE;
        end
      end
    end else if (q_head.bat_weak && q_head.battery_present) begin
      if (q_head.bat_low) begin
        res_next.decision = DEC_SHUTOFF;
      end else begin
        res_next.capacity = est_cap;
        if (est_cap < cfg.min_boot_cap) begin
          res_next.decision        = DEC_LOW_POWER;
          res_next.clear_skip_flag = 1'b1;
        end
      end
    end
  end

  // Payload loads on every pop; no reset needed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: boot power decision bench
// Drives sample sets into the block over its valid/ready input, programs the
// policy registers over APB between phases, and checks every result beat
// field by field against an in-bench prediction of the boot decision.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpd_pkg::*;

  // Voltage limits and the open-circuit capacity table, in millivolts
  localparam int PLUG_LIMIT_MV = 3000;
  localparam int LOW_LIMIT_MV  = 3300;
  localparam int WEAK_LIMIT_MV = 3700;
  localparam int OCV_BIAS_MV   = 62;
  localparam int CAP_NO_STEP   = 15;
  localparam logic [10:0][12:0] OCV_LIMITS = {
    13'd3677, 13'd3673, 13'd3667, 13'd3661, 13'd3649, 13'd3637,
    13'd3624, 13'd3591, 13'd3534, 13'd3477, 13'd3420
  };

  localparam int CYCLE_LIMIT     = 300000;
  localparam int PHASES          = 16;
  localparam int BEATS_PER_PHASE = 84;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic [CODE_W-1:0] wall;
    logic [CODE_W-1:0] usb;
    logic [CODE_W-1:0] bat;
    logic              present;
    logic              skip;
    logic [WORD_W-1:0] saved;
    logic [CAP_W-1:0]  gauge;
  } boot_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CODE_W-1:0] wall_code = '0;
  logic [CODE_W-1:0] usb_code = '0;
  logic [CODE_W-1:0] battery_code = '0;
  logic              battery_present = 1'b0;
  logic              skip_charger_once = 1'b0;
  logic [WORD_W-1:0] saved_cap_word = '0;
  logic [CAP_W-1:0]  gauge_capacity = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        decision;
  logic [PLUG_W-1:0] plug_state;
  logic [MV_W-1:0]   wall_mv;
  logic [MV_W-1:0]   usb_mv;
  logic [MV_W-1:0]   battery_mv;
  logic [CAP_W-1:0]  capacity;
  logic              backlight_low;
  logic              clear_skip_flag;
  logic              disable_usb_wake;

  // Bench copy of the policy registers, updated as each write lands
  bpd_cfg_t    policy;
  bpd_result_t expected_results[$];
  bpd_result_t oldest_result;

  int cycle_count   = 0;
  int error_count   = 0;
  int beats_checked = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_left       = 0;

  boot_power_decision u_top (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .wall_code        (wall_code),
    .usb_code         (usb_code),
    .battery_code     (battery_code),
    .battery_present  (battery_present),
    .skip_charger_once(skip_charger_once),
    .saved_cap_word   (saved_cap_word),
    .gauge_capacity   (gauge_capacity),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .decision         (decision),
    .plug_state       (plug_state),
    .wall_mv          (wall_mv),
    .usb_mv           (usb_mv),
    .battery_mv       (battery_mv),
    .capacity         (capacity),
    .backlight_low    (backlight_low),
    .clear_skip_flag  (clear_skip_flag),
    .disable_usb_wake (disable_usb_wake)
  );

  always #6 clk = ~clk;

  // Watchdog: end the run with an error once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[boot_power_decision] ERROR");
      $finish;
    end
  end

  // Work out the result beat the block owes for one sample set under the
  // current policy registers.
  function automatic bpd_result_t predict_boot(input boot_sample_t s);
    bpd_result_t r;
    int  wmv;
    int  umv;
    int  bmv;
    int  ocv;
    int  cap;
    bit  found;
    r   = '0;
    wmv = int'(s.wall) * 7325 / 1000;
    umv = int'(s.usb) * 7325 / 1000;
    bmv = int'(s.bat) * 5860 / 1000;
    r.wall_mv    = wmv[MV_W-1:0];
    r.usb_mv     = umv[MV_W-1:0];
    r.battery_mv = bmv[MV_W-1:0];
    r.plug_state = {umv > PLUG_LIMIT_MV, wmv > PLUG_LIMIT_MV};
    r.disable_usb_wake = (policy.adaptor_type == ADAPTOR_WALL_ONLY);
    r.decision = DEC_NORMAL;
    if (r.plug_state != PLUG_NONE) begin
      // A stored skip request wins over charge mode and gets cleared
      if (s.skip) begin
        r.clear_skip_flag = 1'b1;
      end else if (policy.charger_mode_enabled && s.present) begin
        if (r.plug_state == PLUG_USB_ONLY) begin
          // USB alone cannot charge a wall-only board
          if (policy.adaptor_type != ADAPTOR_WALL_ONLY) begin
            r.backlight_low = (bmv < LOW_LIMIT_MV);
            r.decision = DEC_CHARGE;
          end
        end else begin
          r.decision = DEC_CHARGE;
        end
      end
    end else if (bmv < WEAK_LIMIT_MV && s.present) begin
      if (bmv < LOW_LIMIT_MV) begin
        r.decision = DEC_SHUTOFF;
      end else begin
        if (policy.use_hw_gauge) begin
          cap = int'(s.gauge);
        end else begin
          // First table step above the open-circuit estimate
          ocv   = bmv + OCV_BIAS_MV;
          cap   = CAP_NO_STEP;
          found = 1'b0;
          for (int i = 0; i < 11; i++) begin
            if (!found && ocv < int'(OCV_LIMITS[i])) begin
              cap   = i;
              found = 1'b1;
            end
          end
          if (s.saved[SAVED_VALID_BIT] && cap > int'(s.saved[14:8])) begin
            cap = int'(s.saved[14:8]);
          end
        end
        r.capacity = cap[CAP_W-1:0];
        if (cap < int'(policy.min_boot_cap)) begin
          r.clear_skip_flag = 1'b1;
          r.decision = DEC_LOW_POWER;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch at result %0d: %s got %0d want %0d",
               beats_checked, what, got, want);
    end
    error_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Receiver: stall at random, or hold off for a counted stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing expected", 1, 0);
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("decision", decision, oldest_result.decision);
        check_field("plug_state", plug_state, oldest_result.plug_state);
        check_field("wall_mv", wall_mv, oldest_result.wall_mv);
        check_field("usb_mv", usb_mv, oldest_result.usb_mv);
        check_field("battery_mv", battery_mv, oldest_result.battery_mv);
        check_field("capacity", capacity, oldest_result.capacity);
        check_field("backlight_low", backlight_low, oldest_result.backlight_low);
        check_field("clear_skip_flag", clear_skip_flag, oldest_result.clear_skip_flag);
        check_field("disable_usb_wake", disable_usb_wake, oldest_result.disable_usb_wake);
      end
      beats_checked++;
    end
  end

  // Offer one beat and hold it until accepted; valid stays high on return so
  // a following beat can go out back to back.
  task automatic send_beat(input boot_sample_t s);
    wall_code         <= s.wall;
    usb_code          <= s.usb;
    battery_code      <= s.bat;
    battery_present   <= s.present;
    skip_charger_once <= s.skip;
    saved_cap_word    <= s.saved;
    gauge_capacity    <= s.gauge;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_boot(s));
  endtask

  // Drop valid for a random number of cycles, per the sender idle rate
  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait out every outstanding result plus the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ADAPTOR_TYPE:    policy.adaptor_type = value[1:0];
      REG_CHARGER_MODE:    policy.charger_mode_enabled = value[0];
      REG_USE_HW_GAUGE:    policy.use_hw_gauge = value[0];
      REG_BOOT_CAP_THRESH: policy.min_boot_cap = value[CAP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Program all four policy registers; junk in the unused upper bits
  task automatic set_policy(input logic [1:0] adaptor, input logic charger,
                            input logic gauge, input logic [CAP_W-1:0] thresh);
    wait_drained();
    write_reg(REG_ADAPTOR_TYPE, {30'($urandom), adaptor});
    write_reg(REG_CHARGER_MODE, {31'($urandom), charger});
    write_reg(REG_USE_HW_GAUGE, {31'($urandom), gauge});
    write_reg(REG_BOOT_CAP_THRESH, {25'($urandom), thresh});
  endtask

  function automatic boot_sample_t make_sample(
      input int wall, input int usb, input int bat, input bit present,
      input bit skip, input int saved, input int gauge);
    boot_sample_t s;
    s.wall    = CODE_W'(wall);
    s.usb     = CODE_W'(usb);
    s.bat     = CODE_W'(bat);
    s.present = present;
    s.skip    = skip;
    s.saved   = WORD_W'(saved);
    s.gauge   = CAP_W'(gauge);
    return s;
  endfunction

  // Mostly pick each plug input on a side of the 3000 mV line and the
  // battery around the shutoff..weak window; the rest is plain noise.
  function automatic boot_sample_t rand_sample();
    boot_sample_t s;
    int plug_pick;
    plug_pick = $urandom_range(3);
    if ($urandom_range(99) < 15) begin
      s.wall = CODE_W'($urandom);
      s.usb  = CODE_W'($urandom);
    end else begin
      s.wall = plug_pick[0] ? CODE_W'($urandom_range(1023, 410)) : CODE_W'($urandom_range(409));
      s.usb  = plug_pick[1] ? CODE_W'($urandom_range(1023, 410)) : CODE_W'($urandom_range(409));
    end
    if ($urandom_range(1)) begin
      s.bat = CODE_W'($urandom_range(640, 555));
    end else begin
      s.bat = CODE_W'($urandom);
    end
    s.present = ($urandom_range(9) != 0);
    s.skip    = ($urandom_range(3) == 0);
    s.saved   = WORD_W'($urandom);
    s.gauge   = CAP_W'($urandom);
    return s;
  endfunction

  // Reset policy: adaptor unknown, charge mode on, table capacity, threshold 7.
  // Walk the voltage edges and each branch of the decision.
  task automatic test_reset_defaults();
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_beat(make_sample(0, 0, 0, 0, 0, 0, 0));
    send_beat(make_sample(1023, 1023, 1023, 1, 1, 'hffff, 127));
    // wall just above the plug line, usb just below
    send_beat(make_sample(410, 409, 700, 1, 0, 0, 0));
    // usb alone with a low battery: charge with backlight low
    send_beat(make_sample(409, 410, 500, 1, 0, 0, 0));
    // no plug: shutoff edge, then just above it
    send_beat(make_sample(0, 0, 563, 1, 0, 0, 0));
    send_beat(make_sample(0, 0, 564, 1, 1, 0, 0));
    // weak-battery edge
    send_beat(make_sample(0, 0, 631, 1, 0, 0, 0));
    send_beat(make_sample(0, 0, 632, 1, 0, 0, 0));
    // first table step
    send_beat(make_sample(0, 0, 573, 1, 0, 0, 0));
    send_beat(make_sample(0, 0, 574, 1, 0, 0, 0));
    // past the last step, capped by a valid saved capacity
    send_beat(make_sample(0, 0, 617, 1, 0, 'h8500, 0));
    // past the last step, saved capacity not valid
    send_beat(make_sample(0, 0, 617, 1, 0, 'h7f00, 0));
    // weak battery but none detected
    send_beat(make_sample(0, 0, 600, 0, 0, 'h8000, 0));
    wait_drained();
  endtask

  // Charge-mode gating by adaptor type and charge enable; gauge capacity
  // against both threshold extremes.
  task automatic test_charge_policies();
    set_policy(ADAPTOR_WALL_ONLY, 1'b1, 1'b0, 7'd7);
    send_beat(make_sample(100, 800, 500, 1, 0, 0, 0));
    send_beat(make_sample(800, 800, 500, 1, 0, 0, 0));
    set_policy(ADAPTOR_WALL_ONLY, 1'b0, 1'b0, 7'd7);
    send_beat(make_sample(800, 0, 700, 1, 0, 0, 0));
    set_policy(ADAPTOR_USB_ONLY, 1'b1, 1'b1, 7'd127);
    send_beat(make_sample(0, 1023, 500, 1, 0, 0, 0));
    send_beat(make_sample(0, 0, 600, 1, 0, 0, 126));
    send_beat(make_sample(0, 0, 600, 1, 0, 0, 127));
    set_policy(ADAPTOR_USB_ONLY, 1'b1, 1'b1, 7'd0);
    send_beat(make_sample(0, 0, 600, 1, 0, 'hffff, 0));
    set_policy(ADAPTOR_BOTH, 1'b1, 1'b0, 7'd0);
    send_beat(make_sample(1023, 1023, 600, 0, 0, 0, 0));
    send_beat(make_sample(0, 0, 600, 1, 0, 'h8000, 0));
    wait_drained();
  endtask

  // Random sample sets across policy settings and idle profiles
  task automatic test_random_phases();
    logic [CAP_W-1:0] thresh;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 5)
        0: thresh = 7'd0;
        1: thresh = 7'd127;
        2: thresh = CAP_W'($urandom_range(16));
        3: thresh = CAP_W'($urandom);
        default: thresh = 7'd15;
      endcase
      set_policy(2'((phase >> 2) & 3), (phase % 3) != 0, (phase % 7) < 3, thresh);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 64; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 64; end
        default: begin sender_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        send_beat(rand_sample());
        sender_gap();
      end
    end
    wait_drained();
  endtask

  // Hold the receiver off while beats keep coming so the queue fills and
  // input ready drops; then pause until every result is back and resume.
  task automatic test_backpressure();
    set_policy(ADAPTOR_BOTH, 1'b1, 1'b0, 7'd7);
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = 200;
    for (int n = 0; n < 40; n++) begin
      send_beat(rand_sample());
    end
    wait_drained();
    stall_pct = 50;
    for (int n = 0; n < 8; n++) begin
      send_beat(rand_sample());
    end
    wait_drained();
  endtask

  initial begin
    policy.adaptor_type         = ADAPTOR_UNKNOWN;
    policy.charger_mode_enabled = 1'b1;
    policy.use_hw_gauge         = 1'b0;
    policy.min_boot_cap         = 7'd7;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_charge_policies();
    test_random_phases();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[boot_power_decision] OK");
    end else begin
      $display("[boot_power_decision] ERROR");
    end
    $finish;
  end

endmodule
